// ===== hdl/vabd_pkg.sv =====
package vabd_pkg;

   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 5;
   localparam int EXTRA_W = 4;
   localparam int COORD_W = 12;
   localparam int KIND_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      DRAW_PIXEL = 2'd0,
      DRAW_LINE  = 2'd1,
      DRAW_MOVE  = 2'd2
   } draw_kind_type;

   typedef enum logic [1:0] {
      CLASS_DROP,
      CLASS_HI,
      CLASS_LO_X,
      CLASS_LO_Y
   } byte_class_type;

   // Position in the address sequence. A lo-X byte always completes a point,
   // so no stored position is needed after hi-X.
   typedef enum logic [1:0] {
      FIELD_HI_Y,
      FIELD_LO_Y,
      FIELD_HI_X
   } field_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              vector_start;
   } req_item_type;

   typedef struct packed {
      draw_kind_type      draw_kind;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } rsp_item_type;

   // Address bytes are 32 to 127; bits 6 and 5 give the byte class.
   function automatic byte_class_type classify(input logic [BYTE_W-1:0] b);
      byte_class_type c;
      unique case (b[7:5])
         3'b001:  c = CLASS_HI;
         3'b010:  c = CLASS_LO_X;
         3'b011:  c = CLASS_LO_Y;
         default: c = CLASS_DROP;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/vabd_if.sv =====
interface vabd_req_if import vabd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              vector_start;

   modport source (output valid, output data_byte, output vector_start, input ready);
   modport sink   (input valid, input data_byte, input vector_start, output ready);
endinterface

interface vabd_rsp_if import vabd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  draw_kind;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;

   modport source (output valid, output draw_kind, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input draw_kind, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

// ===== hdl/vabd_in_reg.sv =====
module vabd_in_reg import vabd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   vabd_req_if.sink     req_bus,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   // The register takes a new request when it is empty or its request moves on.
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte    <= req_bus.data_byte;
         item_ff.vector_start <= req_bus.vector_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/vabd_core.sv =====
module vabd_core import vabd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  logic         advance,
   input  req_item_type item,
   input  logic         point_mode,
   output logic         has_result,
   output rsp_item_type result
);

   logic [FIELD_W-1:0] hi_y_ff, hi_y_in;
   logic [FIELD_W-1:0] lo_y_ff, lo_y_in;
   logic [FIELD_W-1:0] hi_x_ff, hi_x_in;
   logic [EXTRA_W-1:0] extra_ff, extra_in;
   field_index_type    index_ff, index_in;
   logic               lo_y_seen_ff, lo_y_seen_in;
   logic               line_started_ff, line_started_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in;
   logic [COORD_W-1:0] last_y_ff, last_y_in;

   byte_class_type     byte_class;
   logic [FIELD_W-1:0] payload;
   logic               line_live;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;

   assign byte_class = classify(item.data_byte);
   assign payload    = item.data_byte[FIELD_W-1:0];
   // A vector start breaks the line even when the byte itself is dropped.
   assign line_live  = line_started_ff && !item.vector_start;
   assign point_x    = {hi_x_ff, payload, extra_ff[1:0]};
   assign point_y    = {hi_y_ff, lo_y_ff, extra_ff[3:2]};
   assign has_result = item_valid && (byte_class == CLASS_LO_X);

   always_comb begin
      hi_y_in         = hi_y_ff;
      lo_y_in         = lo_y_ff;
      hi_x_in         = hi_x_ff;
      extra_in        = extra_ff;
      index_in        = index_ff;
      lo_y_seen_in    = lo_y_seen_ff;
      line_started_in = line_live;
      last_x_in       = last_x_ff;
      last_y_in       = last_y_ff;

      result.draw_kind = point_mode ? DRAW_PIXEL : (line_live ? DRAW_LINE : DRAW_MOVE);
      result.start_x   = last_x_ff;
      result.start_y   = last_y_ff;
      result.end_x     = point_x;
      result.end_y     = point_y;

      unique case (byte_class)
         CLASS_LO_Y: begin
            if (index_ff != FIELD_HI_X) begin
               index_in     = FIELD_LO_Y;
               lo_y_seen_in = 1'b1;
               lo_y_in      = payload;
               // A second lo-Y byte turns the first one into the extra byte.
               if (lo_y_seen_ff) begin
                  extra_in = lo_y_ff[EXTRA_W-1:0];
               end
            end
         end
         CLASS_HI: begin
            if (index_ff == FIELD_HI_Y) begin
               hi_y_in = payload;
            end else begin
               index_in = FIELD_HI_X;
               hi_x_in  = payload;
            end
         end
         CLASS_LO_X: begin
            index_in     = FIELD_HI_Y;
            lo_y_seen_in = 1'b0;
            last_x_in    = point_x;
            last_y_in    = point_y;
            if (!point_mode) begin
               line_started_in = 1'b1;
            end
         end
         CLASS_DROP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_y_ff         <= '0;
         lo_y_ff         <= '0;
         hi_x_ff         <= '0;
         extra_ff        <= '0;
         index_ff        <= FIELD_HI_Y;
         lo_y_seen_ff    <= 1'b0;
         line_started_ff <= 1'b0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
      end else if (advance) begin
         hi_y_ff         <= hi_y_in;
         lo_y_ff         <= lo_y_in;
         hi_x_ff         <= hi_x_in;
         extra_ff        <= extra_in;
         index_ff        <= index_in;
         lo_y_seen_ff    <= lo_y_seen_in;
         line_started_ff <= line_started_in;
         last_x_ff       <= last_x_in;
         last_y_ff       <= last_y_in;
      end
   end

endmodule

// ===== hdl/vector_address_byte_decoder_unit.sv =====
// Graph-mode address byte decoder. Each request carries one terminal byte
// and a vector-start flag; bytes 32 to 127 are sorted into hi-Y, lo-Y, hi-X
// and lo-X address bytes and assembled into 12-bit X and Y coordinates, and
// every lo-X byte completes a point that leaves as one response: a pixel in
// point mode, otherwise a move for the first point after a vector start and
// a line from the previous point after that. All other bytes produce no
// response. The block accepts one request every clock cycle unless it is
// held up; a response is registered after its request has passed the input
// register. The request sits in the input register while the decode and
// state update fill the response register. Only a full response register
// that is not being read holds up a lo-X byte, and with it the input side.
// The user must write the point_mode register through csr_write_enable
// and csr_write_data only while the block is idle; the block does not enforce this.
module vector_address_byte_decoder_unit import vabd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   vabd_req_if.sink req_bus,
   vabd_rsp_if.source rsp_bus,
   input  logic     csr_write_enable,
   input  logic     csr_write_data
);

   logic         point_mode_ff;
   logic         in_valid;
   req_item_type in_item;
   logic         has_result;
   rsp_item_type core_result;
   logic         advance;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type result_ff;

   // Mode register; the user must write it only while no request is in flight, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         point_mode_ff <= csr_write_data;
      end
   end

   // Input register: holds one request until the decode stage takes it.
   vabd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (in_valid),
      .item       (in_item)
   );

   // Decode and address state, updated once per request that moves on.
   vabd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid),
      .advance    (advance),
      .item       (in_item),
      .point_mode (point_mode_ff),
      .has_result (has_result),
      .result     (core_result)
   );

   // A request that makes no response always moves on. One that completes a
   // point moves on when the response register is empty or being read.
   assign advance = in_valid && (!has_result || !out_valid_ff || rsp_bus.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         result_ff <= core_result;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.draw_kind = result_ff.draw_kind;
   assign rsp_bus.start_x   = result_ff.start_x;
   assign rsp_bus.start_y   = result_ff.start_y;
   assign rsp_bus.end_x     = result_ff.end_x;
   assign rsp_bus.end_y     = result_ff.end_y;

`ifndef NO_ASSERTIONS
   // A request that is held back stays in the input register unchanged.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid && !advance |=> in_valid && $stable(in_item))
      else $error("input register lost or changed a held request");

   // A completed point never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid && has_result && out_valid_ff && !rsp_bus.ready |-> !advance)
      else $error("completed point would overwrite a pending response");

   // A completed point that moves on is presented in the next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> out_valid_ff)
      else $error("completed point was not presented as a response");

   // Reset empties both registers.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid)
      else $error("registers not empty after reset");
`endif

endmodule
